>>> rtl/pftb_pkg.sv
// Shared types and constants of the per-flow token bucket limiter.
`timescale 1ns / 1ps
package pftb_pkg;

  localparam int unsigned NumFlowsDef = 64;
  localparam int unsigned TimeBitsDef = 48;

  localparam int unsigned DelayW  = 22;
  localparam int unsigned TallyW  = 32;
  localparam int unsigned TokW    = 20;
  localparam int unsigned RateW   = 10;
  localparam int unsigned StrikeW = 8;

  typedef enum logic [1:0] {
    FUNC_CHECK   = 2'd0,
    FUNC_RESP    = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OUT_ALLOWED   = 3'd0,
    OUT_THROTTLED = 3'd1,
    OUT_BACKOFF   = 3'd2,
    OUT_BLOCKED   = 3'd3,
    OUT_DONE      = 3'd4
  } outcome_e;

  localparam logic [2:0] CfgBaseRate  = 3'd0;
  localparam logic [2:0] CfgBurst     = 3'd1;
  localparam logic [2:0] CfgBoBase    = 3'd2;
  localparam logic [2:0] CfgBoMax     = 3'd3;
  localparam logic [2:0] CfgAdaptive  = 3'd4;

  // Request to the divider and its answer.
  typedef struct packed {
    logic             start;
    logic [9:0]       num;
    logic [RateW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [9:0]       quo;
  } div_rsp_t;

endpackage

>>> rtl/per_flow_token_bucket_limiter_top.sv
// Top level of the per-flow token bucket limiter: flow table, sequencer, output.
// Steps: read, calc, add, update, write, output, then the result strobe; an item
//   whose result needs a token wait passes through the divider before output.
// One item at a time: busy stays high until the result.
// Reset: clears the init flag, flow valid bits and control registers, sets rate to 1;
//   table entries are undefined until a flow is opened. Results cannot be stalled.
`timescale 1ns / 1ps
module per_flow_token_bucket_limiter_top
  import pftb_pkg::*;
#(
  parameter int unsigned NUM_FLOWS = NumFlowsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [5:0]           flow_id_i,
  input  logic [TIME_BITS-1:0] now_ms_i,
  input  logic [9:0]           status_code_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [11:0]          cfg_data_i,
  output logic                 strobe_o,
  output logic [2:0]           outcome_o,
  output logic [DelayW-1:0]    delay_ms_o,
  output logic [TallyW-1:0]    requests_made_o,
  output logic [TallyW-1:0]    throttled_total_o
);

  localparam int unsigned FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;
  localparam int unsigned EntW = TokW + 2*TIME_BITS + StrikeW + 2*TallyW;
  // ceil(2^37 / 100): floor(x / 100) = (x * Recip100) >> 37 for any 32-bit x
  localparam logic [31:0] Recip100 = 32'h51EB851F;

  typedef struct packed {
    logic [TokW-1:0]      tok;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] dl;
    logic [StrikeW-1:0]   strike;
    logic [TallyW-1:0]    req;
    logic [TallyW-1:0]    thr;
  } ent_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_ADD, ST_UPD, ST_WRITE, ST_DIV, ST_OUT
  } state_e;

  // configuration
  logic [9:0]  base_rate_q, burst_q;
  logic [11:0] bo_base_q, bo_max_q;
  logic        adaptive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rate_q <= 10'd1;
      burst_q     <= 10'd5;
      bo_base_q   <= 12'd5;
      bo_max_q    <= 12'd300;
      adaptive_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBaseRate: base_rate_q <= cfg_data_i[9:0];
        CfgBurst:    burst_q     <= cfg_data_i[9:0];
        CfgBoBase:   bo_base_q   <= cfg_data_i;
        CfgBoMax:    bo_max_q    <= cfg_data_i;
        CfgAdaptive: adaptive_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  logic [9:0]  eff_burst;
  logic [11:0] eff_bo_base, eff_bo_max;
  logic [TokW-1:0] cap;
  assign eff_burst   = (burst_q == '0) ? 10'd5 : burst_q;
  assign eff_bo_base = (bo_base_q == '0) ? 12'd5 : bo_base_q;
  assign eff_bo_max  = (bo_max_q == '0) ? 12'd300 : bo_max_q;
  assign cap = TokW'(eff_burst) * TokW'(1000);

  // flow table memory and valid bits
  ent_t mem [NUM_FLOWS];
  ent_t rd_q;
  logic [NUM_FLOWS-1:0] valid_q;

  // item registers
  state_e state_q;
  logic [1:0]           func_q;
  logic [FW-1:0]        fi_q;
  logic                 ok_q;
  logic [TIME_BITS-1:0] now_q;
  logic [9:0]           code_q;
  logic                 init_q;
  logic [RateW-1:0]     rate_q;
  ent_t                 e_q;
  logic                 fv_q;
  logic [2:0]           out_q;
  logic [TIME_BITS:0]   acc_q;
  logic [TIME_BITS-1:0] el_q;
  logic [25:0]          hund_q;

  logic ok_in;
  assign ok_in = 32'(flow_id_i) < NUM_FLOWS;

  div_req_t dreq;
  div_rsp_t drsp;
  pftb_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // combinational helpers
  logic [RateW-1:0] eff_rate;
  assign eff_rate = (rate_q == '0) ? RateW'(1) : rate_q;
  ent_t cur;
  assign cur = fv_q ? rd_q : ent_t'{tok: cap, last: now_q, dl: '0, strike: '0,
                                    req: '0, thr: '0};
  logic in_bo;
  assign in_bo = (e_q.dl != '0) && (now_q < e_q.dl);

  logic [StrikeW-1:0] nstrike;
  logic [3:0]         sh;
  logic [21:0]        bsh;
  logic [11:0]        blim;
  assign nstrike = (cur.strike == '1) ? cur.strike : cur.strike + 1'b1;
  assign sh   = (nstrike > StrikeW'(10)) ? 4'd9 : 4'(nstrike - 1'b1);
  assign bsh  = 22'(eff_bo_base) << sh;
  assign blim = (bsh > 22'(eff_bo_max)) ? eff_bo_max : bsh[11:0];

  logic [TIME_BITS:0] bo_rem;
  assign bo_rem = {1'b0, e_q.dl} - {1'b0, now_q};

  // request tally divisible by 100: reciprocal quotient registered, checked in the following cycle
  logic [63:0] recip_prod;
  logic        hund_hit;
  assign recip_prod = cur.req * Recip100;
  assign hund_hit   = (32'(hund_q) * 32'd100) == e_q.req;

  // opened entry with the strike update of a response
  ent_t calc_ent;
  always_comb begin
    calc_ent = cur;
    if (func_q == FUNC_RESP && init_q && ok_q) begin
      if (code_q == 10'd429) calc_ent.strike = nstrike;
      else if (code_q >= 10'd200 && code_q < 10'd400) calc_ent.strike = '0;
    end
  end

  // token spend or throttle of a check
  ent_t       upd_ent;
  logic [2:0] upd_out;
  always_comb begin
    upd_ent      = e_q;
    upd_ent.last = now_q;
    if (acc_q >= (TIME_BITS+1)'(cap) && cap >= TokW'(1000)) begin
      upd_ent.tok = cap - TokW'(1000);
      upd_ent.req = (e_q.req == '1) ? e_q.req : e_q.req + 1'b1;
      upd_out     = OUT_ALLOWED;
    end else if (acc_q >= (TIME_BITS+1)'(1000)) begin
      upd_ent.tok = acc_q[TokW-1:0] - TokW'(1000);
      upd_ent.req = (e_q.req == '1) ? e_q.req : e_q.req + 1'b1;
      upd_out     = OUT_ALLOWED;
    end else begin
      upd_ent.tok = (acc_q > (TIME_BITS+1)'(cap)) ? cap : acc_q[TokW-1:0];
      upd_ent.thr = (e_q.thr == '1) ? e_q.thr : e_q.thr + 1'b1;
      upd_out     = OUT_THROTTLED;
    end
  end

  logic need_div;
  assign need_div = init_q && ok_q && fv_q && !in_bo && (e_q.tok < TokW'(1000));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE && ok_q && (func_q == FUNC_CHECK || func_q == FUNC_RESP)
        && init_q)
      mem[fi_q] <= e_q;
    rd_q <= mem[fi_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      init_q   <= 1'b0;
      rate_q   <= RateW'(1);
      valid_q  <= '0;
      strobe_o <= 1'b0;
      dreq     <= '0;
      func_q   <= '0;
      fi_q     <= '0;
      ok_q     <= 1'b0;
    end else begin
      strobe_o   <= (state_q == ST_OUT);
      dreq.start <= (state_q == ST_WRITE) && need_div;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            func_q  <= func_i;
            fi_q    <= FW'(flow_id_i);
            ok_q    <= ok_in;
            now_q   <= now_ms_i;
            code_q  <= status_code_i;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          fv_q    <= valid_q[fi_q];
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          // open, then first half of the operation
          e_q     <= calc_ent;
          hund_q  <= recip_prod[62:37];
          out_q   <= (func_q == FUNC_CHECK && !init_q) ? OUT_BLOCKED : OUT_DONE;
          state_q <= ST_ADD;
          unique case (func_e'(func_q))
            FUNC_RESTART: begin
              init_q  <= 1'b1;
              valid_q <= '0;
              rate_q  <= (base_rate_q == '0) ? RateW'(1) : base_rate_q;
              fv_q    <= 1'b0;
            end
            FUNC_CLEAR: begin
              if (ok_q) begin
                valid_q[fi_q] <= 1'b0;
                fv_q <= 1'b0;
              end
            end
            FUNC_RESP: begin
              if (init_q && ok_q) begin
                valid_q[fi_q] <= 1'b1;
                fv_q <= 1'b1;
                if (code_q == 10'd429) begin
                  acc_q <= {1'b0, now_q} + (TIME_BITS+1)'(blim * 22'd1000);
                  if (adaptive_q && rate_q > RateW'(1))
                    rate_q <= rate_q >> 1;
                end
              end
            end
            FUNC_CHECK: begin
              if (init_q && ok_q) begin
                valid_q[fi_q] <= 1'b1;
                fv_q <= 1'b1;
                el_q <= (now_q >= cur.last) ? now_q - cur.last : '0;
              end
            end
            default: ;
          endcase
        end
        ST_ADD: begin
          state_q <= ST_UPD;
          if (func_q == FUNC_RESP && init_q && ok_q) begin
            if (code_q == 10'd429)
              e_q.dl <= acc_q[TIME_BITS] ? TimeMax : acc_q[TIME_BITS-1:0];
            else if (code_q >= 10'd200 && code_q < 10'd400 && adaptive_q && hund_hit)
              rate_q <= (rate_q < RateW'(9)) ? rate_q + RateW'(1) : RateW'(10);
          end else if (func_q == FUNC_CHECK && init_q && ok_q) begin
            if (in_bo) out_q <= OUT_BACKOFF;
            else if (el_q > TIME_BITS'(cap))
              acc_q <= (TIME_BITS+1)'(e_q.tok) + (TIME_BITS+1)'(cap);
            else
              acc_q <= (TIME_BITS+1)'(e_q.tok) + (TIME_BITS+1)'(el_q[31:0] * eff_rate);
          end
        end
        ST_UPD: begin
          if (func_q == FUNC_CHECK && init_q && ok_q && out_q != OUT_BACKOFF) begin
            e_q   <= upd_ent;
            out_q <= upd_out;
          end
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          // table write; token wait goes through the divider
          if (need_div) begin
            dreq.num <= 10'(TokW'(1000) - e_q.tok);
            dreq.den <= eff_rate;
            state_q  <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (drsp.done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          outcome_o  <= out_q;
          requests_made_o   <= (ok_q && fv_q) ? e_q.req : '0;
          throttled_total_o <= (ok_q && fv_q) ? e_q.thr : '0;
          if (!init_q) delay_ms_o <= DelayW'(1000);
          else if (!ok_q || !fv_q) delay_ms_o <= '0;
          else if (in_bo)
            delay_ms_o <= (bo_rem > (TIME_BITS+1)'(22'h3FFFFF)) ? 22'h3FFFFF
                                                                : bo_rem[DelayW-1:0];
          else if (e_q.tok < TokW'(1000)) delay_ms_o <= DelayW'(drsp.quo);
          else delay_ms_o <= '0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  // assertions
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o) else $error("result strobe held");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> state_q == ST_IDLE) else $error("strobe while busy");
  a_rate_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q != '0) else $error("rate");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule

>>> rtl/pftb_div.sv
// Radix-2 restoring divider for the token wait, one quotient bit per cycle.
`timescale 1ns / 1ps
module pftb_div
  import pftb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [9:0]       quo_q, quo_d;
  logic [RateW-1:0] rem_q, rem_d;
  logic [RateW-1:0] den_q, den_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RateW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[9]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit in and try the subtract
      if (trial >= {1'b0, den_q}) begin
        rem_d = RateW'(trial - {1'b0, den_q});
        quo_d = {quo_q[8:0], 1'b1};
      end else begin
        rem_d = trial[RateW-1:0];
        quo_d = {quo_q[8:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd9) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
